### hw/rtl/nearest_waypoint_path_end_assert.svh
// Assertion macros shared by the nearest waypoint path end RTL.
`ifndef NEAREST_WAYPOINT_PATH_END_ASSERT_SVH
`define NEAREST_WAYPOINT_PATH_END_ASSERT_SVH

// Clocked check, disabled while reset is held.
`define NWPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define NWPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/nwpe_pkg.sv
// Package: types, constants and tables of the nearest waypoint path end block.
`default_nettype none
package nwpe_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int ADDR_W       = $clog2(MAX_POINTS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int IDX_W        = 10;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int LA_W         = 24;
  localparam int GAIN_W       = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [2:0] REG_LOOKAHEAD = 3'd0;

  localparam logic signed [33:0] ATAN_TURN [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } cmd_t;

  typedef struct packed {
    logic             speed_command;
    logic             ended_flag;
    logic [IDX_W-1:0] nearest_index;
  } res_t;

endpackage
`default_nettype wire

### hw/rtl/nearest_waypoint_path_end.sv
// Top level: nearest waypoint search with sticky path end flag.
// Usage:
//  Input stream (s_axis): one request per item; action 0 clears the path,
//  action 1 appends a waypoint, action 2 queries with the vehicle pose.
//  Action 3 is accepted and dropped. Requests enter a 4-deep command queue
//  and are presented to the back end from the registered queue entries.
//  Output stream (m_axis): one result per query, none for other actions.
//  Clear and append complete in the accept step of the back end. A query
//  with N stored points runs in the back end through these steps: accept,
//  gain multiply and angle fold, 24 CORDIC iterations, steer, N waypoint
//  reads from the single read port of the waypoint memory, the drain of the
//  distance pipeline, then the output register. A query on an empty path
//  goes from accept straight to the output register.
//  Reset empties the path, clears the path end flag and sets the lookahead
//  to 0; the waypoint memory is not cleared and needs no sweep.
//  When the receiver stalls the result waits in the output register; the
//  queue keeps taking requests until it is full, then s_axis_tready drops.
//  The lookahead register sits at APB address 0.
`default_nettype none
module nearest_waypoint_path_end import nwpe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // action[1:0], pos_x[33:2], pos_y[65:34], heading[81:66], zero pad
  input  wire logic [87:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // speed_command[0], ended_flag[1], nearest_index[11:2], zero pad
  output logic [15:0]      m_axis_tdata_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [LA_W-1:0] la_q;
  logic            cmd_valid, cmd_ready;
  cmd_t            cmd;
  res_t            res;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LOOKAHEAD) ? 32'(la_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q <= '0;
    end else if (psel && penable && pwrite && paddr == REG_LOOKAHEAD) begin
      la_q <= pwdata[LA_W-1:0];
    end
  end

  nwpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  nwpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .lookahead_i (la_q),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {4'b0, res.nearest_index, res.ended_flag, res.speed_command};

endmodule
`default_nettype wire

### hw/rtl/nwpe_front.sv
// Front end: accepts input requests, decodes the action and queues commands.
`default_nettype none
`include "nearest_waypoint_path_end_assert.svh"
module nwpe_front import nwpe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [87:0] s_tdata_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output cmd_t             cmd_o
);

  cmd_t              q_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop, known;
  cmd_t              cmd_in;

  always_comb begin
    known        = 1'b1;
    cmd_in.op    = OP_CLEAR;
    cmd_in.pos_x = signed'(s_tdata_i[33:2]);
    cmd_in.pos_y = signed'(s_tdata_i[65:34]);
    cmd_in.heading = s_tdata_i[81:66];
    case (s_tdata_i[1:0])
      ACT_CLEAR:  cmd_in.op = OP_CLEAR;
      ACT_APPEND: cmd_in.op = OP_APPEND;
      ACT_QUERY:  cmd_in.op = OP_QUERY;
      default:    known = 1'b0;
    endcase
  end

  assign s_tready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rd_ptr_q];
  assign push        = s_tvalid_i & s_tready_o & known;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

  `NWPE_ASSERT(a_q_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
  `NWPE_ASSERT(a_q_ptrs, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue pointers differ")
  `NWPE_ASSERT(a_q_keep, (cmd_valid_o && !cmd_ready_i) |=> cmd_valid_o, "queued request lost")

endmodule
`default_nettype wire

### hw/rtl/nwpe_back.sv
// Back end: waypoint store, steer point CORDIC, pipelined nearest scan, result register.
`default_nettype none
`include "nearest_waypoint_path_end_assert.svh"
module nwpe_back import nwpe_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cmd_t                 cmd_i,
  input  wire logic [LA_W-1:0] lookahead_i,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  output res_t                 res_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_GAIN  = 7'b0000010,
    ST_FOLD  = 7'b0000100,
    ST_ROT   = 7'b0001000,
    ST_STEER = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_RES   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [63:0]        mem_q [MAX_POINTS];
  logic [CNT_W-1:0]   count_q, count_d;
  logic               done_q, done_d;
  logic signed [31:0] px_q, py_q;
  logic [15:0]        hd_q;
  logic [53:0]        prod_q;
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic signed [33:0] sx_q, sx_d, sy_q, sy_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  res_t               pend_q, pend_d;
  res_t               out_q;
  logic               ov_q;

  logic               wr_en, rd_en;
  logic [63:0]        rd_q;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [ADDR_W-1:0]  i1_q, i2_q, i3_q, i4_q, i5_q;
  logic [34:0]        mx_q, my_q;
  logic [33:0]        xaa_q, yaa_q;
  logic [34:0]        xab_q, yab_q;
  logic [35:0]        xbb_q, ybb_q;
  logic [69:0]        x2_q, y2_q;
  logic [70:0]        sum_q;
  logic [70:0]        best_q;
  logic [ADDR_W-1:0]  bidx_q;

  logic signed [16:0] s_fold;
  logic               neg_fold;
  logic signed [35:0] x_sh, y_sh, xr, yr, dxo, dyo;
  logic signed [34:0] dxw, dyw;
  logic               load_out, ended;

  always_comb begin
    s_fold   = 17'(signed'(hd_q));
    neg_fold = 1'b0;
    if (s_fold > 17'sd16384) begin
      s_fold   = s_fold - 17'sd32768;
      neg_fold = 1'b1;
    end else if (s_fold < -17'sd16384) begin
      s_fold   = s_fold + 17'sd32768;
      neg_fold = 1'b1;
    end
  end

  assign x_sh = x_q >>> step_q;
  assign y_sh = y_q >>> step_q;
  assign xr   = x_q + 36'sd128;
  assign yr   = y_q + 36'sd128;
  assign dxo  = xr >>> 8;
  assign dyo  = yr >>> 8;
  assign ended = done_q | ((count_q - 1'b1) == CNT_W'(bidx_q));
  assign load_out = !ov_q || m_tready_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    done_d      = done_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    step_d      = step_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    iss_d       = iss_q;
    pend_d      = pend_q;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_CLEAR: count_d = '0;
            OP_APPEND: begin
              if (count_q < CNT_W'(MAX_POINTS)) begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_q == '0) begin
                pend_d.speed_command = 1'b0;
                pend_d.ended_flag    = done_q;
                pend_d.nearest_index = '0;
                state_d = ST_RES;
              end else begin
                state_d = ST_GAIN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_GAIN: state_d = ST_FOLD;
      ST_FOLD: begin
        x_d = neg_fold ? -signed'({4'b0, prod_q[53:22]}) : signed'({4'b0, prod_q[53:22]});
        y_d = '0;
        z_d = 34'(signed'({s_fold, 16'b0}));
        step_d  = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        if (!z_q[33]) begin
          x_d = x_q - y_sh;
          y_d = y_q + x_sh;
          z_d = z_q - ATAN_TURN[step_q];
        end else begin
          x_d = x_q + y_sh;
          y_d = y_q - x_sh;
          z_d = z_q + ATAN_TURN[step_q];
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_STEER;
        end
      end
      ST_STEER: begin
        sx_d    = 34'(px_q) + 34'(dxo);
        sy_d    = 34'(py_q) + 34'(dyo);
        iss_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (iss_q != count_q) begin
          rd_en = 1'b1;
          iss_d = iss_q + 1'b1;
        end else if (!(v1_q | v2_q | v3_q | v4_q | v5_q)) begin
          done_d = ended;
          pend_d.speed_command = !ended;
          pend_d.ended_flag    = ended;
          pend_d.nearest_index = IDX_W'(bidx_q);
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      ov_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      step_q  <= '0;
      iss_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      step_q  <= step_d;
      iss_q   <= iss_d;
      v1_q    <= rd_en;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      if (state_q == ST_RES && load_out) begin
        ov_q <= 1'b1;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[ADDR_W-1:0]] <= {cmd_i.pos_x, cmd_i.pos_y};
    end
    if (rd_en) begin
      rd_q <= mem_q[iss_q[ADDR_W-1:0]];
    end
  end

  always_comb begin
    dxw = 35'(sx_q) - 35'(signed'(rd_q[63:32]));
    dyw = 35'(sy_q) - 35'(signed'(rd_q[31:0]));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && cmd_i.op == OP_QUERY) begin
      px_q <= cmd_i.pos_x;
      py_q <= cmd_i.pos_y;
      hd_q <= cmd_i.heading;
    end
    prod_q <= 54'(lookahead_i) * 54'(GAIN_Q30);
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    pend_q <= pend_d;
    i1_q   <= iss_q[ADDR_W-1:0];
    i2_q   <= i1_q;
    i3_q   <= i2_q;
    i4_q   <= i3_q;
    i5_q   <= i4_q;
    mx_q   <= dxw[34] ? 35'(-dxw) : 35'(dxw);
    my_q   <= dyw[34] ? 35'(-dyw) : 35'(dyw);
    xaa_q  <= mx_q[34:18] * mx_q[34:18];
    xab_q  <= mx_q[34:18] * mx_q[17:0];
    xbb_q  <= mx_q[17:0] * mx_q[17:0];
    yaa_q  <= my_q[34:18] * my_q[34:18];
    yab_q  <= my_q[34:18] * my_q[17:0];
    ybb_q  <= my_q[17:0] * my_q[17:0];
    x2_q   <= {xaa_q, 36'b0} + {16'b0, xab_q, 19'b0} + {34'b0, xbb_q};
    y2_q   <= {yaa_q, 36'b0} + {16'b0, yab_q, 19'b0} + {34'b0, ybb_q};
    sum_q  <= {1'b0, x2_q} + {1'b0, y2_q};
    if (v5_q && (i5_q == '0 || sum_q < best_q)) begin
      best_q <= sum_q;
      bidx_q <= i5_q;
    end
    if (state_q == ST_RES && load_out) begin
      out_q <= pend_q;
    end
  end

  assign m_tvalid_o = ov_q;
  assign res_o      = out_q;

  `NWPE_ASSERT(a_done_sticky, done_q |=> done_q, "path end flag cleared")
  `NWPE_ASSERT(a_scan_bound, rd_en |-> (iss_q < count_q), "scan read past path end")
  `NWPE_ASSERT(a_pipe_in_scan, v5_q |-> (state_q == ST_SCAN), "scan result outside scan")

endmodule
`default_nettype wire

### sim/tb_nearest_waypoint_path_end.sv
// Testbench for nearest_waypoint_path_end: table of directed requests, then random paths and queries.
`default_nettype none
module tb_nearest_waypoint_path_end;
  import nwpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2000000;
  localparam int DRAIN = 1200;
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [87:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #10 clk_i = ~clk_i;

  nearest_waypoint_path_end dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // path model
  logic [31:0] way_x [MAX_POINTS];
  logic [31:0] way_y [MAX_POINTS];
  int unsigned n_points = 0;
  bit end_seen = 1'b0;
  logic [23:0] lookahead = '0;

  res_t pending_q[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned n_items = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;

  typedef struct {
    logic [1:0] act;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] hdg;
    bit typed;
    res_t want;
  } row_t;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  task automatic steer(input logic [15:0] hdg, output longint dx, output longint dy);
    longint s, x, y, z, nx;
    logic [63:0] p;
    s = longint'(hdg);
    if (s >= 32768) s -= 65536;
    p = 64'(lookahead) * 64'(GAIN_Q30);
    x = longint'(p >> 22);
    y = 0;
    if (s > 16384) begin
      s -= 32768;
      x = -x;
    end else if (s < -16384) begin
      s += 32768;
      x = -x;
    end
    z = s * 65536;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(ATAN_TURN[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(ATAN_TURN[i]);
      end
      x = nx;
    end
    dx = (x + 128) >>> 8;
    dy = (y + 128) >>> 8;
  endtask

  // returns 1 when the request yields a result
  task automatic predict_path(input logic [1:0] act, input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] hdg, output bit has_res, output res_t r);
    longint dx, dy, sx, sy;
    logic signed [127:0] ex, ey;
    logic [127:0] d, best_d;
    int unsigned best;
    has_res = 1'b0;
    r = '0;
    best = 0;
    case (act)
      ACT_CLEAR: n_points = 0;
      ACT_APPEND: if (n_points < MAX_POINTS) begin
        way_x[n_points] = x;
        way_y[n_points] = y;
        n_points++;
      end
      ACT_QUERY: begin
        if (n_points > 0) begin
          steer(hdg, dx, dy);
          sx = longint'(signed'(x)) + dx;
          sy = longint'(signed'(y)) + dy;
          for (int unsigned i = 0; i < n_points; i++) begin
            ex = 128'(sx) - 128'(signed'(way_x[i]));
            ey = 128'(sy) - 128'(signed'(way_y[i]));
            d = ex * ex + ey * ey;
            if (i == 0 || d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          if (best + 1 == n_points) end_seen = 1'b1;
        end
        r.speed_command = (n_points == 0 || end_seen) ? 1'b0 : 1'b1;
        r.ended_flag = end_seen;
        r.nearest_index = best[IDX_W-1:0];
        has_res = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send(row_t rw);
    bit has_res;
    res_t r;
    while (!calm && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, rw.hdg, rw.y, rw.x, rw.act};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_path(rw.act, rw.x, rw.y, rw.hdg, has_res, r);
    if (has_res) pending_q.push_back(rw.typed ? rw.want : r);
    n_items++;
  endtask

  task automatic req(logic [1:0] act, logic [31:0] x, logic [31:0] y, logic [15:0] hdg);
    row_t rw;
    rw = '{act, x, y, hdg, 1'b0, '0};
    send(rw);
  endtask

  task automatic settle;
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (pready !== 1'b1) report("pready", int'(pready), 1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'({REG_LOOKAHEAD, 2'b00})) lookahead = val[23:0];
    paddr <= 3'd0;
    @(posedge clk_i);
    if (prdata !== 32'(lookahead)) report("prdata", int'(prdata), int'(lookahead));
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [15:0] rnd_heading();
    logic [15:0] pick [8] = '{16'd0, 16'd16384, 16'd16385, 16'd32768, 16'd49151,
                              16'd49152, 16'd65535, 16'd32767};
    if ($urandom_range(0, 3) == 0) return pick[$urandom_range(0, 7)];
    return 16'($urandom());
  endfunction

  task automatic random_phase(int unsigned quota);
    int unsigned stop, npts, nq, k;
    stop = n_items + quota;
    while (n_items < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: req(ACT_NONE, $urandom(), $urandom(), 16'($urandom()));
          1: req(ACT_QUERY, $urandom(), $urandom(), 16'($urandom()));
          default: req(ACT_CLEAR, $urandom(), $urandom(), 16'($urandom()));
        endcase
      end else begin
        req(ACT_CLEAR, $urandom(), $urandom(), 16'($urandom()));
        npts = $urandom_range(1, 30);
        repeat (npts) req(ACT_APPEND, rnd_coord(), rnd_coord(), 16'($urandom()));
        nq = $urandom_range(2, 8);
        repeat (nq) begin
          if (n_points > 0 && $urandom_range(0, 2) != 0) begin
            k = $urandom_range(0, n_points - 1);
            req(ACT_QUERY, way_x[k] + 32'($urandom_range(0, 32'h40000)) - 32'h20000,
                way_y[k] + 32'($urandom_range(0, 32'h40000)) - 32'h20000, rnd_heading());
          end else begin
            req(ACT_QUERY, rnd_coord(), rnd_coord(), rnd_heading());
          end
        end
      end
    end
  endtask

  row_t directed [] = '{
    '{ACT_QUERY,  32'h0,         32'h0,         16'd0,     1'b1, '{1'b0, 1'b0, 10'd0}},
    '{ACT_NONE,   32'hffff_ffff, 32'hffff_ffff, 16'hffff,  1'b0, '0},
    '{ACT_APPEND, 32'h8000_0000, 32'h8000_0000, 16'd0,     1'b0, '0},
    '{ACT_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 16'd0,     1'b0, '0},
    '{ACT_APPEND, 32'h0,         32'h0,         16'd0,     1'b0, '0},
    '{ACT_APPEND, 32'h0001_0000, 32'h0,         16'd0,     1'b0, '0},
    '{ACT_APPEND, 32'h0,         32'h0001_0000, 16'd0,     1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd0,     1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd16384, 1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd16385, 1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd32768, 1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd49151, 1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd49152, 1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd65535, 1'b0, '0},
    '{ACT_QUERY,  32'h7fff_ffff, 32'h7fff_ffff, 16'd8192,  1'b0, '0},
    '{ACT_QUERY,  32'h8000_0000, 32'h8000_0000, 16'd40000, 1'b0, '0},
    '{ACT_APPEND, 32'h0000_8000, 32'h0000_8000, 16'd0,     1'b0, '0},
    '{ACT_QUERY,  32'h0002_0000, 32'h0002_0000, 16'd0,     1'b0, '0},
    '{ACT_CLEAR,  32'h0,         32'h0,         16'd0,     1'b0, '0},
    '{ACT_QUERY,  32'h1234_5678, 32'h8765_4321, 16'd100,   1'b1, '{1'b0, 1'b1, 10'd0}},
    '{ACT_APPEND, 32'h0005_0000, 32'h0005_0000, 16'd0,     1'b0, '0},
    '{ACT_QUERY,  32'h0,         32'h0,         16'd0,     1'b1, '{1'b0, 1'b1, 10'd0}}
  };

  // result checker
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.speed_command = m_tdata[0];
      got.ended_flag = m_tdata[1];
      got.nearest_index = m_tdata[11:2];
      if (pending_q.size() == 0) begin
        report("unexpected result", int'(m_tdata), -1);
      end else begin
        want = pending_q.pop_front();
        if (got.speed_command !== want.speed_command)
          report("speed_command", got.speed_command, want.speed_command);
        if (got.ended_flag !== want.ended_flag)
          report("ended_flag", got.ended_flag, want.ended_flag);
        if (got.nearest_index !== want.nearest_index)
          report("nearest_index", got.nearest_index, want.nearest_index);
      end
    end
  end

  // receiver: random stalls, one long hold-off
  int unsigned hold_left = 0;
  bit held = 1'b0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !held) begin
      m_tready <= 1'b0;
      hold_left <= 600;
      held <= 1'b1;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send(directed[i]);
    settle();
    apb_write(3'd4, 32'hdead_beef);
    apb_write(3'd0, 32'hff01_0000);
    hold_go = 1'b1;
    random_phase(140);
    settle();
    apb_write(3'd0, 32'h00ff_ffff);
    calm = 1'b1;
    random_phase(140);
    calm = 1'b0;
    settle();
    apb_write(3'd0, 32'h0);
    random_phase(130);
    settle();
    apb_write(3'd0, $urandom());
    random_phase(140);
    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
